@@ rtl/gcdpf_pkg.sv @@
// ----------------------------------------------------------------------------
// gcdpf_pkg
// Shared constants for the prime-factorization GCD unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gcdpf_pkg;

   // default operand width used inside the datapath
   localparam int VALUE_BITS_DEFAULT = 16;

   // width of the operand and result fields on the ports
   localparam int FIELD_BITS = 16;

endpackage

`default_nettype wire

@@ rtl/gcdpf_div.sv @@
// ----------------------------------------------------------------------------
// gcdpf_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder
// hold once busy drops until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module gcdpf_div #(
   parameter int VALUE_BITS = gcdpf_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [VALUE_BITS-1:0] divisor,
   output logic                       busy,
   output logic [VALUE_BITS-1:0]      quotient,
   output logic [VALUE_BITS-1:0]      remainder
);

   localparam int CW = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] den_ff, den_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;
   logic                  ge;

   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_BITS-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;

      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = CW'(VALUE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
         quo_in = {quo_ff[VALUE_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/gcd_by_prime_factorization_unit.sv @@
// ----------------------------------------------------------------------------
// gcd_by_prime_factorization_unit
// Greatest common divisor of two operands by trial-division factoring.
// ----------------------------------------------------------------------------
// One request beat in, one response beat out. Operands are cut to VALUE_BITS.
// The first operand is factored by trial division with candidates 2, 3, 4, ...
// while candidate squared <= what is left of it; every factor found is also
// tried on the second operand, and each shared factor is multiplied into the
// result. A leftover prime above one is tried last. A zero operand returns
// error with divisor 0. Each trial division runs through one shared
// bit-serial divider. The request side stalls while an item is in work; a
// finished response sits in an output register and the next request is
// taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_by_prime_factorization_unit #(
   parameter int VALUE_BITS = gcdpf_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [gcdpf_pkg::FIELD_BITS-1:0] req_first_value,
   input  wire logic [gcdpf_pkg::FIELD_BITS-1:0] req_second_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [gcdpf_pkg::FIELD_BITS-1:0]      rsp_divisor,
   output logic                                  rsp_error
);

   localparam int VB = VALUE_BITS;
   localparam int PW = (VB + 1) / 2 + 1;
   localparam int SW = 2 * PW;
   localparam int FB = gcdpf_pkg::FIELD_BITS;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CHECK = 8'b0000_0010,
      S_DIVA  = 8'b0000_0100,
      S_DIVB  = 8'b0000_1000,
      S_MUL   = 8'b0001_0000,
      S_FDIV  = 8'b0010_0000,
      S_FMUL  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [VB-1:0] a_ff, a_in;
   logic [VB-1:0] b_ff, b_in;
   logic [VB-1:0] prod_ff, prod_in;
   logic [VB-1:0] fac_ff, fac_in;
   logic [PW-1:0] p_ff, p_in;
   logic [SW-1:0] sq_ff, sq_in;
   logic          err_ff, err_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [FB-1:0] rsp_divisor_ff, rsp_divisor_in;
   logic          rsp_error_ff, rsp_error_in;

   logic [VB-1:0] op_a, op_b;
   logic          div_start;
   logic [VB-1:0] div_dividend, div_divisor;
   logic          div_busy;
   logic [VB-1:0] div_quo, div_rem;
   logic          out_free;

   gcdpf_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign op_a     = VB'(req_first_value);
   assign op_b     = VB'(req_second_value);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      prod_in      = prod_ff;
      fac_in       = fac_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      err_in       = err_ff;
      div_start    = 1'b0;
      div_dividend = a_ff;
      div_divisor  = VB'(p_ff);

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_divisor_in = rsp_divisor_ff;
      rsp_error_in   = rsp_error_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a_in    = op_a;
               b_in    = op_b;
               p_in    = PW'(2);
               sq_in   = SW'(4);
               prod_in = VB'(1);
               if (op_a == '0 || op_b == '0) begin
                  err_in   = 1'b1;
                  prod_in  = '0;
                  state_in = S_DONE;
               end else begin
                  err_in   = 1'b0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (sq_ff <= SW'(a_ff)) begin
               div_start = 1'b1;
               state_in  = S_DIVA;
            end else if (a_ff > VB'(1)) begin
               div_start    = 1'b1;
               div_dividend = b_ff;
               div_divisor  = a_ff;
               state_in     = S_FDIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIVA: begin
            if (!div_busy) begin
               if (div_rem == '0) begin
                  a_in         = div_quo;
                  div_start    = 1'b1;
                  div_dividend = b_ff;
                  state_in     = S_DIVB;
               end else begin
                  p_in     = p_ff + 1'b1;
                  sq_in    = sq_ff + SW'({p_ff, 1'b1});
                  state_in = S_CHECK;
               end
            end
         end
         S_DIVB: begin
            if (!div_busy) begin
               if (div_rem == '0) begin
                  b_in     = div_quo;
                  fac_in   = VB'(p_ff);
                  state_in = S_MUL;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIVA;
               end
            end
         end
         S_MUL: begin
            prod_in   = VB'(prod_ff * fac_ff);
            div_start = 1'b1;
            state_in  = S_DIVA;
         end
         S_FDIV: begin
            if (!div_busy) begin
               if (div_rem == '0) begin
                  fac_in   = a_ff;
                  state_in = S_FMUL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FMUL: begin
            prod_in  = VB'(prod_ff * fac_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_divisor_in = FB'(prod_ff);
               rsp_error_in   = err_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff           <= a_in;
      b_ff           <= b_in;
      prod_ff        <= prod_in;
      fac_ff         <= fac_in;
      p_ff           <= p_in;
      sq_ff          <= sq_in;
      err_ff         <= err_in;
      rsp_divisor_ff <= rsp_divisor_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_divisor = rsp_divisor_ff;
   assign rsp_error   = rsp_error_ff;

endmodule

`default_nettype wire
